// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file.
// Each macro wraps one concurrent assertion that reports through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication that must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rbnv_pkg.sv -----
// ----------------------------------------------------------------------------
// rbnv_pkg
// Types and constants of the ready-bit negotiation vector.
// ----------------------------------------------------------------------------
package rbnv_pkg;

    localparam int VEC_BYTES   = 128;
    localparam int HANDLE_BITS = 32;
    localparam int ROW_W       = $clog2(VEC_BYTES);
    localparam int SLOT_W      = ROW_W + 3;
    localparam int NSLOTS      = 8 * VEC_BYTES;
    localparam int FINISH_SLOT = NSLOTS - 2;
    localparam int CNT_W       = 10;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_FINISH = 2'd1;
    localparam logic [1:0] REQ_BYTE   = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_DUPLICATE = 3'd1;
    localparam logic [2:0] KIND_READY     = 3'd2;
    localparam logic [2:0] KIND_FINISH    = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_DONE      = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ADD,
        ST_FIN,
        ST_PREP,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/ready_bit_negotiation_vector.sv -----
// ----------------------------------------------------------------------------
// ready_bit_negotiation_vector
// Slot bitmap with handle table, driven by add, mark-finish and vector bytes.
// ----------------------------------------------------------------------------
// Usage
//   An item is accepted at a rising edge where start is high and busy is low.
//   The item carries req_type and the fields that type needs: an add uses
//   msg_index and req_handle, a mark-finish uses nothing else, and a reduced
//   vector byte uses byte_index, byte_value and last_byte.
//   Each result appears on the result ports for exactly one cycle, flagged by
//   result_valid; last marks the final result that an item causes. The
//   receiver cannot stall, so results are never held back.
//   An add or a mark-finish keeps busy high in the read and the add or finish
//   state; its one result passes the issue stage and the output registers. A
//   vector byte keeps busy high in the read, prep and scan states, and in the
//   done state when last_byte asks for the check-done result. One bit of the
//   byte is scanned per cycle from bit 7 down; each result takes the same path.
//   The eight-step scan, sharing one handle-table read port, sets the byte rate.
//   Reset clears all slot state at once through one valid flag per bitmap
//   row, so no clearing pass is needed and an item may start right away.
// ----------------------------------------------------------------------------
module ready_bit_negotiation_vector
    import rbnv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             req_type,
    input  logic [SLOT_W-1:0]      msg_index,
    input  logic [HANDLE_BITS-1:0] req_handle,
    input  logic [ROW_W-1:0]       byte_index,
    input  logic [7:0]             byte_value,
    input  logic                   last_byte,
    output logic                   result_valid,
    output logic [2:0]             kind,
    output logic [SLOT_W-1:0]      slot,
    output logic [HANDLE_BITS-1:0] handle_out,
    output logic [CNT_W-1:0]       ready_count,
    output logic [CNT_W-1:0]       pending_count,
    output logic                   last_round,
    output logic                   last
);

    localparam logic [ROW_W-1:0]  FIN_ROW = ROW_W'(FINISH_SLOT / 8);
    localparam logic [2:0]        FIN_BIT = 3'(FINISH_SLOT % 8);
    localparam logic [SLOT_W-1:0] FIN_SLOT_V = SLOT_W'(FINISH_SLOT);

    // Each bitmap row holds the pending byte in the upper half and the
    // per-slot "handle stored" bits in the lower half.
    logic [15:0]            row_mem [VEC_BYTES];
    logic [HANDLE_BITS-1:0] handle_mem [NSLOTS];

    state_t state_reg, state_next;

    // Latched item fields.
    logic [1:0]             type_reg;
    logic [SLOT_W-1:0]      idx_reg;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic [ROW_W-1:0]       bidx_reg;
    logic [7:0]             bval_reg;
    logic                   lastb_reg;

    // Counters and flags.
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic [CNT_W-1:0] tally_reg, tally_next;
    logic             round_reg, round_next;
    logic [2:0]       k_reg, k_next;
    logic [VEC_BYTES-1:0] row_vld_reg, row_vld_next;

    // Row held during the bit scan.
    logic [7:0] pend_h_reg, pend_h_next;
    logic [7:0] val_h_reg, val_h_next;

    // Memory read data.
    logic [15:0]            row_q;
    logic                   row_ok_q;
    logic [HANDLE_BITS-1:0] handle_q;

    // Memory control.
    logic [ROW_W-1:0]  row_addr;
    logic              row_we;
    logic [15:0]       row_wdata;
    logic              hdl_we;
    logic [SLOT_W-1:0] hdl_addr;

    // Issue stage: a result whose handle is being read.
    logic              s1_valid_reg, s1_valid_next;
    logic [2:0]        s1_kind_reg, s1_kind_next;
    logic [SLOT_W-1:0] s1_slot_reg, s1_slot_next;
    logic [CNT_W-1:0]  s1_rc_reg, s1_rc_next;
    logic              s1_last_reg, s1_last_next;

    // Output registers.
    logic                   out_valid_reg;
    logic [2:0]             out_kind_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [CNT_W-1:0]       out_rc_reg;
    logic [CNT_W-1:0]       out_pend_reg;
    logic                   out_round_reg;
    logic                   out_last_reg;

    // Effective row contents: a row never written since reset reads as zero.
    logic [7:0]        eff_pend;
    logic [7:0]        eff_val;
    logic [3:0]        hit_cnt;
    logic [7:0]        low_mask;
    logic [SLOT_W-1:0] scan_slot;
    logic              accept;

    assign accept    = start && (state_reg == ST_IDLE);
    assign eff_pend  = row_ok_q ? row_q[15:8] : 8'd0;
    assign eff_val   = row_ok_q ? row_q[7:0]  : 8'd0;
    assign low_mask  = (8'd1 << k_reg) - 8'd1;
    assign scan_slot = {bidx_reg, k_reg};

    always_comb
    begin
        hit_cnt = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            hit_cnt = hit_cnt + {3'd0, bval_reg[i] & eff_val[i]};
        end
    end

    // Row address follows the latched request type.
    always_comb
    begin
        case (type_reg)
            REQ_ADD:    row_addr = idx_reg[SLOT_W-1:3];
            REQ_FINISH: row_addr = FIN_ROW;
            default:    row_addr = bidx_reg;
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                case (type_reg)
                    REQ_ADD:    state_next = ST_ADD;
                    REQ_FINISH: state_next = ST_FIN;
                    REQ_BYTE:
                    begin
                        if ({1'b0, bidx_reg} < (ROW_W + 1)'(VEC_BYTES))
                        begin
                            state_next = ST_PREP;
                        end
                        else if (lastb_reg)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_ADD:  state_next = ST_IDLE;
            ST_FIN:  state_next = ST_IDLE;
            ST_PREP: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (k_reg == 3'd0)
                begin
                    state_next = lastb_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and result issue.
    always_comb
    begin
        pending_next  = pending_reg;
        tally_next    = tally_reg;
        round_next    = round_reg;
        k_next        = k_reg;
        row_vld_next  = row_vld_reg;
        pend_h_next   = pend_h_reg;
        val_h_next    = val_h_reg;
        row_we        = 1'b0;
        row_wdata     = 16'd0;
        hdl_we        = 1'b0;
        hdl_addr      = idx_reg;
        s1_valid_next = 1'b0;
        s1_kind_next  = KIND_ADDED;
        s1_slot_next  = '0;
        s1_rc_next    = '0;
        s1_last_next  = 1'b1;
        case (state_reg)
            ST_ADD:
            begin
                s1_valid_next = 1'b1;
                s1_slot_next  = idx_reg;
                if (({1'b0, idx_reg} >= (SLOT_W + 1)'(NSLOTS)) || eff_pend[idx_reg[2:0]])
                begin
                    s1_kind_next = KIND_DUPLICATE;
                end
                else
                begin
                    s1_kind_next = KIND_ADDED;
                    row_we       = 1'b1;
                    row_wdata    = {eff_pend | (8'd1 << idx_reg[2:0]),
                                    eff_val  | (8'd1 << idx_reg[2:0])};
                    row_vld_next[row_addr] = 1'b1;
                    hdl_we       = 1'b1;
                    pending_next = pending_reg + CNT_W'(1);
                end
            end
            ST_FIN:
            begin
                s1_valid_next = 1'b1;
                s1_kind_next  = KIND_ADDED;
                s1_slot_next  = FIN_SLOT_V;
                row_we        = 1'b1;
                row_wdata     = {eff_pend | (8'd1 << FIN_BIT), eff_val};
                row_vld_next[row_addr] = 1'b1;
                pending_next  = pending_reg + CNT_W'(1);
            end
            ST_PREP:
            begin
                // Totals after the whole byte are settled before any result leaves.
                pend_h_next  = eff_pend;
                val_h_next   = eff_val;
                pending_next = pending_reg - CNT_W'(hit_cnt);
                tally_next   = tally_reg + CNT_W'(hit_cnt);
                if ((bidx_reg == FIN_ROW) && bval_reg[FIN_BIT] && !eff_val[FIN_BIT])
                begin
                    round_next = 1'b1;
                end
                k_next = 3'd7;
            end
            ST_SCAN:
            begin
                hdl_addr      = scan_slot;
                s1_valid_next = bval_reg[k_reg];
                s1_slot_next  = scan_slot;
                s1_last_next  = !lastb_reg && ((bval_reg & low_mask) == 8'd0);
                if (val_h_reg[k_reg])
                begin
                    s1_kind_next = KIND_READY;
                end
                else if (scan_slot == FIN_SLOT_V)
                begin
                    s1_kind_next = KIND_FINISH;
                end
                else
                begin
                    s1_kind_next = KIND_NOT_FOUND;
                end
                if (k_reg == 3'd0)
                begin
                    row_we    = 1'b1;
                    row_wdata = {pend_h_reg ^ bval_reg, val_h_reg & ~bval_reg};
                    row_vld_next[row_addr] = 1'b1;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            ST_DONE:
            begin
                s1_valid_next = 1'b1;
                s1_kind_next  = KIND_DONE;
                s1_rc_next    = tally_reg;
                tally_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Memories: registered reads, one write port each.
    always_ff @(posedge clk)
    begin
        row_q    <= row_mem[row_addr];
        row_ok_q <= row_vld_reg[row_addr];
        if (row_we)
        begin
            row_mem[row_addr] <= row_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        handle_q <= handle_mem[hdl_addr];
        if (hdl_we)
        begin
            handle_mem[hdl_addr] <= hdl_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg  <= req_type;
            idx_reg   <= msg_index;
            hdl_reg   <= req_handle;
            bidx_reg  <= byte_index;
            bval_reg  <= byte_value;
            lastb_reg <= last_byte;
        end
        k_reg          <= k_next;
        pend_h_reg     <= pend_h_next;
        val_h_reg      <= val_h_next;
        s1_kind_reg    <= s1_kind_next;
        s1_slot_reg    <= s1_slot_next;
        s1_rc_reg      <= s1_rc_next;
        s1_last_reg    <= s1_last_next;
        out_kind_reg   <= s1_kind_reg;
        out_slot_reg   <= s1_slot_reg;
        out_handle_reg <= (s1_kind_reg == KIND_READY) ? handle_q : '0;
        out_rc_reg     <= s1_rc_reg;
        out_pend_reg   <= pending_reg;
        out_round_reg  <= round_reg;
        out_last_reg   <= s1_last_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pending_reg   <= '0;
            tally_reg     <= '0;
            round_reg     <= 1'b0;
            row_vld_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            tally_reg     <= tally_next;
            round_reg     <= round_next;
            row_vld_reg   <= row_vld_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_valid  = out_valid_reg;
    assign kind          = out_kind_reg;
    assign slot          = out_slot_reg;
    assign handle_out    = out_handle_reg;
    assign ready_count   = out_rc_reg;
    assign pending_count = out_pend_reg;
    assign last_round    = out_round_reg;
    assign last          = out_last_reg;

endmodule

// ----- hdl/rbnv_checker.sv -----
// ----------------------------------------------------------------------------
// rbnv_checker
// Port-level checks of the ready-bit negotiation vector, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbnv_checker
    import rbnv_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   result_valid,
    input logic [2:0]             kind,
    input logic [HANDLE_BITS-1:0] handle_out,
    input logic [CNT_W-1:0]       ready_count,
    input logic                   last
);

    // An accepted item always occupies the sequencer for the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted item did not set busy")

    // Add, mark-finish and check-done results are always the final one of an item.
    `ASSERT_IMPL(a_single_last, clk, rst_n, result_valid && (kind == KIND_ADDED || kind == KIND_DUPLICATE || kind == KIND_DONE), last, "single result without last")

    // Only a ready result carries a handle.
    `ASSERT_IMPL(a_handle_zero, clk, rst_n, result_valid && kind != KIND_READY, handle_out == '0, "handle on non-ready result")

    // Only check done carries a count.
    `ASSERT_IMPL(a_count_zero, clk, rst_n, result_valid && kind != KIND_DONE, ready_count == '0, "count on non-done result")

endmodule

bind ready_bit_negotiation_vector rbnv_checker u_rbnv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind),
    .handle_out   (handle_out),
    .ready_count  (ready_count),
    .last         (last)
);
